// ----- rtl/core/dmxfr_pkg.sv -----
package dmxfr_pkg;

  localparam int CHANNELS  = 8;
  localparam int FRAME_LEN = 2 * CHANNELS;
  localparam int CH_W      = 3;
  localparam int ADDR_W    = 9;
  localparam int OFS_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int VAL_W     = 16;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_BREAK = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              framing_error;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_index;
    logic [VAL_W-1:0] channel_value;
    logic             last_channel;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [CH_W-1:0]   row;
    logic              high;
    logic [BYTE_W-1:0] data;
  } wr_cmd_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] row;
  } rd_cmd_t;

endpackage

// ----- rtl/core/dmxfr_frame_store.sv -----
module dmxfr_frame_store (
  input  logic                      clk,
  input  dmxfr_pkg::wr_cmd_t        wr,
  input  dmxfr_pkg::rd_cmd_t        rd,
  output logic [dmxfr_pkg::VAL_W-1:0] rd_data
);
  import dmxfr_pkg::*;

  logic [BYTE_W-1:0] lo_mem [CHANNELS];
  logic [BYTE_W-1:0] hi_mem [CHANNELS];
  logic [VAL_W-1:0]  rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en && !wr.high) begin
      lo_mem[wr.row] <= wr.data;
    end
    if (wr.en && wr.high) begin
      hi_mem[wr.row] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= {hi_mem[rd.row], lo_mem[rd.row]};
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/dmxfr_rx_tracker.sv -----
module dmxfr_rx_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  dmxfr_pkg::in_item_t          in_item,
  input  logic [dmxfr_pkg::ADDR_W-1:0] start_address,
  output dmxfr_pkg::wr_cmd_t           wr,
  output logic                         frame_done
);
  import dmxfr_pkg::*;

  logic [1:0]       mode_r, mode_nxt;
  logic [OFS_W-1:0] ofs_r, ofs_nxt;
  logic             in_range;

  assign in_range = !ofs_r[OFS_W-1] && (ofs_r < OFS_W'(FRAME_LEN));

  always_comb begin
    mode_nxt   = mode_r;
    ofs_nxt    = ofs_r;
    frame_done = 1'b0;
    wr.en      = 1'b0;
    wr.row     = ofs_r[CH_W:1];
    wr.high    = ofs_r[0];
    wr.data    = in_item.data_byte;
    if (in_accept) begin
      if (in_item.framing_error) begin
        mode_nxt = MODE_BREAK;
      end else begin
        case (mode_r)
          MODE_BREAK: begin
            mode_nxt = (in_item.data_byte != '0) ? MODE_IDLE : MODE_FRAME;
            ofs_nxt  = OFS_W'(0) - {{(OFS_W-ADDR_W){1'b0}}, start_address};
          end
          MODE_FRAME: begin
            wr.en   = in_range;
            ofs_nxt = ofs_r + OFS_W'(1);
            if (ofs_r == OFS_W'(FRAME_LEN - 1)) begin
              mode_nxt   = MODE_IDLE;
              frame_done = 1'b1;
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      ofs_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      ofs_r  <= ofs_nxt;
    end
  end

endmodule

// ----- rtl/core/dmxfr_readout.sv -----
module dmxfr_readout (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dmxfr_pkg::VAL_W-1:0] rd_data,
  input  logic                        out_stall,
  output dmxfr_pkg::rd_cmd_t          rd,
  output logic                        busy,
  output logic                        out_valid,
  output dmxfr_pkg::out_item_t        out_item
);
  import dmxfr_pkg::*;

  localparam logic [1:0] RO_IDLE = 2'd0;
  localparam logic [1:0] RO_READ = 2'd1;
  localparam logic [1:0] RO_LOAD = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;
  logic            is_last;

  assign is_last = (ch_r == CH_W'(CHANNELS - 1));

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    rd.en         = 1'b0;
    rd.row        = ch_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      RO_IDLE: begin
        if (start) begin
          state_nxt = RO_READ;
          ch_nxt    = '0;
        end
      end
      RO_READ: begin
        rd.en     = 1'b1;
        state_nxt = RO_LOAD;
      end
      RO_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.channel_index  = ch_r;
          out_item_nxt.channel_value  = rd_data;
          out_item_nxt.last_channel   = is_last;
          if (is_last) begin
            state_nxt = RO_IDLE;
            ch_nxt    = '0;
          end else begin
            state_nxt = RO_READ;
            ch_nxt    = ch_r + CH_W'(1);
          end
        end
      end
      default: begin
        state_nxt = RO_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RO_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != RO_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/dmx512_frame_receiver.sv -----
// Channel  Handshake          Payload
// in_      in_valid/in_stall  in_data: data_byte, framing_error
// out_     out_valid/out_stall out_data: channel_index, channel_value, last_channel
// cfg_     cfg_valid/cfg_ready cfg_data: start_address
//
// A received byte is taken whenever in_valid is high and in_stall is low. The
// byte that completes a frame starts a readout of the two-byte-wide frame
// store: a memory read and an output load alternate for each of the CHANNELS
// results, out_stall can hold the output register, and input is stalled
// meanwhile. Synchronous reset clears the mode, slot offset, start address
// and output valid; the frame store is not cleared.
module dmx512_frame_receiver (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dmxfr_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dmxfr_pkg::out_item_t         out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dmxfr_pkg::ADDR_W-1:0] cfg_data
);
  import dmxfr_pkg::*;

  logic [ADDR_W-1:0] start_address_r;
  logic              in_accept;
  logic              frame_done;
  logic              busy;
  wr_cmd_t           wr;
  rd_cmd_t           rd;
  logic [VAL_W-1:0]  rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_address_r <= cfg_data;
    end
  end

  dmxfr_rx_tracker u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .in_item       (in_data),
    .start_address (start_address_r),
    .wr            (wr),
    .frame_done    (frame_done)
  );

  dmxfr_frame_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  dmxfr_readout u_readout (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (frame_done),
    .rd_data   (rd_data),
    .out_stall (out_stall),
    .rd        (rd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  a_done_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> in_stall)
    else $error("input not stalled after frame completion");

  a_stall_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(frame_done))
    else $error("readout started without a completed frame");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en |-> !wr.en)
    else $error("frame store written during readout");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import dmxfr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 2 * FRAME_LEN + 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   cfg_data = '0;

  dmx512_frame_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Predicted receiver state.
  logic [1:0]              p_mode = MODE_IDLE;
  logic signed [OFS_W-1:0] p_ofs = '0;
  logic [ADDR_W-1:0]       p_start = '0;
  logic [BYTE_W-1:0]       p_bytes [FRAME_LEN];

  out_item_t expected_channels[$];
  out_item_t directed_channels[$];

  int mismatches = 0;
  int frames_done = 0;
  int bytes_taken = 0;
  int channels_checked = 0;
  int quiet_cycles = 0;
  int sender_gap_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;
  int cur_start = 0;
  int result_transfers = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  in_item_t directed_bytes [26] = '{
    '{8'hA5, 1'b0}, '{8'h00, 1'b1}, '{8'h07, 1'b0}, '{8'hFF, 1'b1}, '{8'h00, 1'b0},
    '{8'h11, 1'b0}, '{8'h22, 1'b0}, '{8'h00, 1'b1}, '{8'h80, 1'b1}, '{8'h00, 1'b0},
    '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
    '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'h00, 1'b0}, '{8'h01, 1'b0}, '{8'h80, 1'b0},
    '{8'h80, 1'b0}, '{8'h01, 1'b0}, '{8'h34, 1'b0}, '{8'h12, 1'b0}, '{8'hFE, 1'b0},
    '{8'h7F, 1'b0}
  };

  logic [VAL_W-1:0] directed_values [CHANNELS] = '{
    16'hFFFF, 16'h0000, 16'hFF00, 16'h00FF, 16'h8001, 16'h0180, 16'h1234, 16'h7FFE
  };

  function automatic void predict_frame_byte(in_item_t it);
    out_item_t res;
    if (it.framing_error) begin
      p_mode = MODE_BREAK;
      return;
    end
    if (p_mode == MODE_BREAK) begin
      p_mode = (it.data_byte != 8'h00) ? MODE_IDLE : MODE_FRAME;
      p_ofs = -$signed({2'b00, p_start});
      return;
    end
    if (p_mode != MODE_FRAME) return;
    if (p_ofs >= 0 && p_ofs < FRAME_LEN) p_bytes[p_ofs[3:0]] = it.data_byte;
    p_ofs = p_ofs + 11'sd1;
    if (p_ofs < FRAME_LEN) return;
    p_mode = MODE_IDLE;
    frames_done++;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      res.channel_index = CH_W'(ch);
      res.channel_value = {p_bytes[2 * ch + 1], p_bytes[2 * ch]};
      res.last_channel  = (ch == CHANNELS - 1);
      if (directed_channels.size() != 0)
        expected_channels.push_back(directed_channels.pop_front());
      else expected_channels.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        channels_checked++;
        if (expected_channels.size() == 0) begin
          $error("Unexpected channel result: index %0d value %h", out_data.channel_index,
                 out_data.channel_value);
          mismatches++;
        end else begin
          exp_item = expected_channels.pop_front();
          if (out_data.channel_index !== exp_item.channel_index) begin
            $error("channel_index: expected %0d, got %0d", exp_item.channel_index,
                   out_data.channel_index);
            mismatches++;
          end
          if (out_data.channel_value !== exp_item.channel_value) begin
            $error("channel_value: expected %h, got %h", exp_item.channel_value,
                   out_data.channel_value);
            mismatches++;
          end
          if (out_data.last_channel !== exp_item.last_channel) begin
            $error("last_channel: expected %0b, got %0b", exp_item.last_channel,
                   out_data.last_channel);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) p_start = cfg_data;
      if (in_valid && !in_stall) begin
        bytes_taken++;
        predict_frame_byte(in_data);
      end
    end
  end

  // Once, part way into the run, the output side holds off long enough for the
  // block to back up and stall its input while bytes keep being offered.
  always @(posedge clk) begin
    if (out_valid && !out_stall) result_transfers <= result_transfers + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && result_transfers == 30) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fe);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, framing_error: fe};
    bytes_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_start_address(input int addr);
    cfg_valid <= 1'b1;
    cfg_data  <= ADDR_W'(addr);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_start = addr;
  endtask

  task automatic settle_receiver();
    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
    send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_random_sequence();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      repeat ($urandom_range(1, 2)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      send_byte(8'h00, 1'b0);
      repeat (cur_start + FRAME_LEN) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else if (kind == 8) begin
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      send_byte(8'h00, 1'b0);
      repeat ($urandom_range(0, cur_start + FRAME_LEN - 1))
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int phase_frames;
    int gap_by_phase [3];
    int stall_by_phase [3];
    gap_by_phase   = '{24, 49, 0};
    stall_by_phase = '{49, 24, 0};

    for (int ch = 0; ch < CHANNELS; ch++) begin
      directed_channels.push_back('{channel_index: CH_W'(ch),
                                    channel_value: directed_values[ch],
                                    last_channel: (ch == CHANNELS - 1)});
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_gap_pct = gap_by_phase[0];
    recv_stall_pct = stall_by_phase[0];
    foreach (directed_bytes[k]) send_byte(directed_bytes[k].data_byte,
                                          directed_bytes[k].framing_error);
    settle_receiver();

    write_start_address((1 << ADDR_W) - 1);
    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
    send_byte(8'h00, 1'b0);
    repeat (8) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    settle_receiver();

    for (int ph = 0; ph < 3; ph++) begin
      sender_gap_pct = gap_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      if (ph == 0) write_start_address($urandom_range(1, 4));
      else if (ph == 1) write_start_address(0);
      else write_start_address($urandom_range(1, 6));
      phase_frames = frames_done;
      while (frames_done - phase_frames < 1)
        send_random_sequence();
      settle_receiver();
    end

    $display("Sent %0d bytes with breaks, bad start codes and abandoned frames,",
             bytes_taken);
    $display("checked %0d channel results from %0d frames; start addresses ran up to 511.",
             channels_checked, frames_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
